// ===== hdl/srv6_pkg.sv =====
// ----------------------------------------------------------------------------
// srv6_pkg
// Shared types, constants and the header word table of the SRv6 L2 encapsulator.
// ----------------------------------------------------------------------------
package srv6_pkg;

    localparam int unsigned WORD_W      = 16;
    localparam int unsigned VB_W        = 2;
    localparam int unsigned LEN_W       = 12;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned MAC_W       = 48;
    localparam int unsigned IP_W        = 128;

    localparam int unsigned MAX_PAYLOAD = 2048;
    localparam int unsigned PLEN_ADD    = 24;
    localparam int unsigned HDR_WORDS   = 39;
    localparam int unsigned HDR_CNT_W   = $clog2(HDR_WORDS + 1);

    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] ETH_TYPE_V6      = 16'h86DD;
    localparam logic [15:0] IPV6_VER_WORD    = 16'h6000;
    localparam logic [7:0]  NEXT_HDR_ROUTING = 8'h2B;
    localparam logic [7:0]  HOP_LIMIT        = 8'd63;
    localparam logic [7:0]  SRH_NEXT_HDR     = 8'h8F;
    localparam logic [7:0]  SRH_HDR_LEN      = 8'h02;
    localparam logic [7:0]  SRH_TYPE         = 8'h04;
    localparam logic [7:0]  SRH_SEG_LEFT     = 8'h00;

    localparam logic [VB_W-1:0] VB_ONE = 2'd1;
    localparam logic [VB_W-1:0] VB_TWO = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_IP_HIGH  = 3'd0,
        CFG_SRC_IP_LOW   = 3'd1,
        CFG_DST_IP_HIGH  = 3'd2,
        CFG_DST_IP_LOW   = 3'd3,
        CFG_NEXT_HOP_MAC = 3'd4,
        CFG_OWN_MAC      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [IP_W-1:0]  src_ip;
        logic [IP_W-1:0]  dst_ip;
        logic [MAC_W-1:0] next_hop_mac;
        logic [MAC_W-1:0] own_mac;
    } cfg_t;

    // one queued transaction: a normalized word plus frame markers
    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic [VB_W-1:0]   vb;
        logic              first;
        logic              last;
        logic [LEN_W-1:0]  plen;   // IPv6 payload length, already saturated and offset
    } entry_t;

    function automatic logic [15:0] word_of_ip(logic [IP_W-1:0] ip, logic [2:0] k);
        logic [15:0] w;
        w = ip[IP_W - 1 - 16 * k -: 16];
        return w;
    endfunction

    function automatic logic [15:0] hdr_word(logic [HDR_CNT_W-1:0] idx,
                                             logic [LEN_W-1:0] plen,
                                             cfg_t cfg);
        logic [15:0] w;
        case (idx) inside
            6'd0:            w = cfg.next_hop_mac[47:32];
            6'd1:            w = cfg.next_hop_mac[31:16];
            6'd2:            w = cfg.next_hop_mac[15:0];
            6'd3:            w = cfg.own_mac[47:32];
            6'd4:            w = cfg.own_mac[31:16];
            6'd5:            w = cfg.own_mac[15:0];
            6'd6:            w = ETH_TYPE_V6;
            6'd7:            w = IPV6_VER_WORD;
            6'd9:            w = {{(16 - LEN_W){1'b0}}, plen};
            6'd10:           w = {NEXT_HDR_ROUTING, HOP_LIMIT};
            [6'd11:6'd18]:   w = word_of_ip(cfg.src_ip, 3'(idx - 6'd11));
            [6'd19:6'd26]:   w = word_of_ip(cfg.dst_ip, 3'(idx - 6'd19));
            6'd27:           w = {SRH_NEXT_HDR, SRH_HDR_LEN};
            6'd28:           w = {SRH_TYPE, SRH_SEG_LEFT};
            [6'd31:6'd38]:   w = word_of_ip(cfg.dst_ip, 3'(idx - 6'd31));
            default:         w = 16'h0000;  // flow label low, last entry/flags, tag
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/srv6_if.sv =====
// ----------------------------------------------------------------------------
// srv6 stream interfaces
// Valid/ready channels for inner frame words and encapsulated packet words.
// ----------------------------------------------------------------------------
interface srv6_in_if;
    logic                           valid;
    logic                           ready;
    logic [srv6_pkg::WORD_W-1:0]    data_word;
    logic [srv6_pkg::VB_W-1:0]      valid_bytes;
    logic                           first_word;
    logic                           last_word;
    logic [srv6_pkg::LEN_W-1:0]     payload_bytes;

    modport source (
        output valid, data_word, valid_bytes, first_word, last_word, payload_bytes,
        input  ready
    );
    modport sink (
        input  valid, data_word, valid_bytes, first_word, last_word, payload_bytes,
        output ready
    );
endinterface

interface srv6_out_if;
    logic                           valid;
    logic                           ready;
    logic [srv6_pkg::WORD_W-1:0]    out_word;
    logic [srv6_pkg::VB_W-1:0]      out_valid_bytes;
    logic                           run_end;
    logic                           packet_end;

    modport source (
        output valid, out_word, out_valid_bytes, run_end, packet_end,
        input  ready
    );
    modport sink (
        input  valid, out_word, out_valid_bytes, run_end, packet_end,
        output ready
    );
endinterface

// ===== hdl/srv6_l2_encapsulator.sv =====
// ----------------------------------------------------------------------------
// srv6_l2_encapsulator
// SRv6 L2 encapsulation with one segment: outer Ethernet, IPv6 and SRH.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries inner frame words (16 bits, first byte high); out_ch carries
//   the encapsulated packet. A transaction moves when valid and ready are high.
//   The config port (cfg_wr_en, cfg_index, cfg_data) loads addresses and MACs;
//   write it only while no frame is in flight.
//   A word flagged first_word produces 39 header words and then itself; every
//   later word of the frame produces only itself. Words outside a frame are
//   accepted and dropped.
//   An accepted word passes through the queue and then the output register
//   before it shows on out_ch. Throughput is one output word per cycle while
//   out_ch is ready, set by the single output register; the input takes one
//   word per cycle while the 4-entry queue has room, so it back-pressures
//   during each header burst. Reset clears the queue, the open-frame flag,
//   the output valid and all config registers. When out_ch stalls, the output
//   word holds and the queue fills; in_ch.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module srv6_l2_encapsulator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [srv6_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srv6_pkg::CFG_DATA_W-1:0]     cfg_data,
    srv6_in_if.sink                             in_ch,
    srv6_out_if.source                          out_ch
);

    srv6_pkg::cfg_t     cfg_reg;
    srv6_pkg::entry_t   push_entry;
    srv6_pkg::entry_t   head;
    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (srv6_pkg::cfg_idx_t'(cfg_index))
                srv6_pkg::CFG_SRC_IP_HIGH:  cfg_reg.src_ip[127:64] <= cfg_data;
                srv6_pkg::CFG_SRC_IP_LOW:   cfg_reg.src_ip[63:0]   <= cfg_data;
                srv6_pkg::CFG_DST_IP_HIGH:  cfg_reg.dst_ip[127:64] <= cfg_data;
                srv6_pkg::CFG_DST_IP_LOW:   cfg_reg.dst_ip[63:0]   <= cfg_data;
                srv6_pkg::CFG_NEXT_HOP_MAC:
                    cfg_reg.next_hop_mac <= cfg_data[srv6_pkg::MAC_W-1:0];
                srv6_pkg::CFG_OWN_MAC:
                    cfg_reg.own_mac <= cfg_data[srv6_pkg::MAC_W-1:0];
                default: ;
            endcase
        end
    end

    srv6_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry)
    );

    srv6_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .head       (head),
        .empty      (fifo_empty)
    );

    srv6_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .empty  (fifo_empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

// ===== hdl/srv6_front.sv =====
// ----------------------------------------------------------------------------
// srv6_front
// Accepts inner frame words, drops words outside a frame, normalizes the rest.
// ----------------------------------------------------------------------------
module srv6_front (
    input  logic                clk,
    input  logic                rst_n,
    srv6_in_if.sink             in_ch,
    input  logic                fifo_full,
    output logic                push,
    output srv6_pkg::entry_t    push_entry
);

    logic frame_open_reg;
    logic frame_open_next;
    logic accepted;
    logic keep;
    logic [srv6_pkg::LEN_W-1:0] len_sat;

    assign in_ch.ready = ~fifo_full;
    assign accepted    = in_ch.valid & in_ch.ready;
    assign keep        = in_ch.first_word | frame_open_reg;
    assign push        = accepted & keep;

    always_comb
    begin
        if (in_ch.payload_bytes > srv6_pkg::LEN_W'(srv6_pkg::MAX_PAYLOAD))
        begin
            len_sat = srv6_pkg::LEN_W'(srv6_pkg::MAX_PAYLOAD);
        end
        else
        begin
            len_sat = in_ch.payload_bytes;
        end
    end

    always_comb
    begin
        push_entry.first = in_ch.first_word;
        push_entry.last  = in_ch.last_word;
        push_entry.plen  = len_sat + srv6_pkg::LEN_W'(srv6_pkg::PLEN_ADD);
        if (in_ch.valid_bytes == srv6_pkg::VB_ONE)
        begin
            push_entry.data = {in_ch.data_word[15:8], 8'h00};
            push_entry.vb   = srv6_pkg::VB_ONE;
        end
        else
        begin
            push_entry.data = in_ch.data_word;
            push_entry.vb   = srv6_pkg::VB_TWO;
        end
    end

    always_comb
    begin
        frame_open_next = frame_open_reg;
        if (push)
        begin
            frame_open_next = ~in_ch.last_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

// ===== hdl/srv6_fifo.sv =====
// ----------------------------------------------------------------------------
// srv6_fifo
// Short queue between front and back; head entry is shown without a pop.
// ----------------------------------------------------------------------------
module srv6_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  srv6_pkg::entry_t    push_entry,
    output logic                full,
    input  logic                pop,
    output srv6_pkg::entry_t    head,
    output logic                empty
);

    srv6_pkg::entry_t                   mem [srv6_pkg::FIFO_DEPTH];
    logic [srv6_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [srv6_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [srv6_pkg::FIFO_CNT_W-1:0]    count_reg, count_next;

    assign full  = (count_reg == srv6_pkg::FIFO_CNT_W'(srv6_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/srv6_back.sv =====
// ----------------------------------------------------------------------------
// srv6_back
// Expands queued frame starts into the outer header burst, then emits words.
// ----------------------------------------------------------------------------
module srv6_back (
    input  logic                clk,
    input  logic                rst_n,
    input  srv6_pkg::cfg_t      cfg,
    input  srv6_pkg::entry_t    head,
    input  logic                empty,
    output logic                pop,
    srv6_out_if.source          out_ch
);

    logic [srv6_pkg::HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic                           valid_reg, valid_next;
    logic [srv6_pkg::WORD_W-1:0]    word_reg, word_next;
    logic [srv6_pkg::VB_W-1:0]      vb_reg, vb_next;
    logic                           run_end_reg, run_end_next;
    logic                           pkt_end_reg, pkt_end_next;
    logic                           out_free;
    logic                           load;
    logic                           in_header;

    assign out_free  = ~valid_reg | out_ch.ready;
    assign load      = out_free & ~empty;
    assign in_header = head.first
                     & (hdr_cnt_reg != srv6_pkg::HDR_CNT_W'(srv6_pkg::HDR_WORDS));
    assign pop       = load & ~in_header;

    always_comb
    begin
        hdr_cnt_next = hdr_cnt_reg;
        valid_next   = valid_reg & ~out_ch.ready;
        word_next    = word_reg;
        vb_next      = vb_reg;
        run_end_next = run_end_reg;
        pkt_end_next = pkt_end_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (in_header)
            begin
                hdr_cnt_next = hdr_cnt_reg + 1'b1;
                word_next    = srv6_pkg::hdr_word(hdr_cnt_reg, head.plen, cfg);
                vb_next      = srv6_pkg::VB_TWO;
                run_end_next = 1'b0;
                pkt_end_next = 1'b0;
            end
            else
            begin
                hdr_cnt_next = '0;
                word_next    = head.data;
                vb_next      = head.vb;
                run_end_next = 1'b1;
                pkt_end_next = head.last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        vb_reg      <= vb_next;
        run_end_reg <= run_end_next;
        pkt_end_reg <= pkt_end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            hdr_cnt_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            hdr_cnt_reg <= hdr_cnt_next;
        end
    end

    assign out_ch.valid           = valid_reg;
    assign out_ch.out_word        = word_reg;
    assign out_ch.out_valid_bytes = vb_reg;
    assign out_ch.run_end         = run_end_reg;
    assign out_ch.packet_end      = pkt_end_reg;

endmodule

// ===== hdl/srv6_checker.sv =====
// ----------------------------------------------------------------------------
// srv6_checker
// Port-level checks on the encapsulated output stream.
// ----------------------------------------------------------------------------
module srv6_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [srv6_pkg::WORD_W-1:0]     out_word,
    input  logic [srv6_pkg::VB_W-1:0]       out_valid_bytes,
    input  logic                            run_end,
    input  logic                            packet_end
);

    // output valid must not drop while stalled
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    // packet end only on the word that ends a run
    a_pkt_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_end |-> run_end)
        else $error("packet_end without run_end");

    // header words are always full words
    a_hdr_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_end |-> out_valid_bytes == srv6_pkg::VB_TWO)
        else $error("header word with partial byte count");

    a_vb_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_valid_bytes == srv6_pkg::VB_ONE
                   || out_valid_bytes == srv6_pkg::VB_TWO)
        else $error("illegal out_valid_bytes");

    // a single-byte word has its unused low byte cleared
    a_odd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_valid_bytes == srv6_pkg::VB_ONE |-> out_word[7:0] == 8'h00)
        else $error("low byte not cleared on single-byte word");

endmodule

bind srv6_l2_encapsulator srv6_checker u_srv6_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_word        (out_ch.out_word),
    .out_valid_bytes (out_ch.out_valid_bytes),
    .run_end         (out_ch.run_end),
    .packet_end      (out_ch.packet_end)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives inner frame words into the SRv6 L2 encapsulator and checks every
// encapsulated word against a local predictor of the outer Ethernet, IPv6 and
// SRH headers, under several address configurations and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HDR_BITS     = srv6_pkg::HDR_WORDS * srv6_pkg::WORD_W;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [srv6_pkg::WORD_W-1:0] word;
        logic [srv6_pkg::VB_W-1:0]   vb;
        logic                        run_end;
        logic                        packet_end;
    } enc_word_t;

    logic clk;
    logic rst_n;
    logic                            cfg_wr_en;
    logic [srv6_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [srv6_pkg::CFG_DATA_W-1:0] cfg_data;

    srv6_in_if  in_ch();
    srv6_out_if out_ch();

    srv6_l2_encapsulator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    logic [srv6_pkg::IP_W-1:0]  exp_src_ip;
    logic [srv6_pkg::IP_W-1:0]  exp_dst_ip;
    logic [srv6_pkg::MAC_W-1:0] exp_next_hop_mac;
    logic [srv6_pkg::MAC_W-1:0] exp_own_mac;
    logic                       exp_frame_open;
    enc_word_t                  pending_words[$];

    int errors;
    int words_checked;
    int items_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Expected output words for one accepted input word.
    function automatic void predict_encap(input logic [srv6_pkg::WORD_W-1:0] data,
                                          input logic [srv6_pkg::VB_W-1:0] vb,
                                          input logic first,
                                          input logic last,
                                          input logic [srv6_pkg::LEN_W-1:0] plen);
        logic [HDR_BITS-1:0] hdr;
        logic [15:0]         ip_len;
        int unsigned         len_sat;
        enc_word_t           w;
        if (!first && !exp_frame_open)
            return;
        if (first)
        begin
            len_sat = (plen > srv6_pkg::MAX_PAYLOAD) ? srv6_pkg::MAX_PAYLOAD : plen;
            ip_len  = 16'(len_sat + srv6_pkg::PLEN_ADD);
            hdr = {exp_next_hop_mac, exp_own_mac, srv6_pkg::ETH_TYPE_V6,
                   srv6_pkg::IPV6_VER_WORD, 16'h0000, ip_len,
                   srv6_pkg::NEXT_HDR_ROUTING, srv6_pkg::HOP_LIMIT,
                   exp_src_ip, exp_dst_ip,
                   srv6_pkg::SRH_NEXT_HDR, srv6_pkg::SRH_HDR_LEN,
                   srv6_pkg::SRH_TYPE, srv6_pkg::SRH_SEG_LEFT, 32'h0,
                   exp_dst_ip};
            for (int i = 0; i < srv6_pkg::HDR_WORDS; i++)
            begin
                w.word       = hdr[HDR_BITS-1-srv6_pkg::WORD_W*i -: srv6_pkg::WORD_W];
                w.vb         = srv6_pkg::VB_TWO;
                w.run_end    = 1'b0;
                w.packet_end = 1'b0;
                pending_words.push_back(w);
            end
        end
        // one valid byte keeps only the upper half; anything else counts as two
        if (vb == srv6_pkg::VB_ONE)
        begin
            w.word = data & 16'hFF00;
            w.vb   = srv6_pkg::VB_ONE;
        end
        else
        begin
            w.word = data;
            w.vb   = srv6_pkg::VB_TWO;
        end
        w.run_end    = 1'b1;
        w.packet_end = last;
        pending_words.push_back(w);
        exp_frame_open = !last;
    endfunction

    task automatic write_reg(input srv6_pkg::cfg_idx_t idx,
                             input logic [srv6_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            srv6_pkg::CFG_SRC_IP_HIGH:  exp_src_ip[127:64] = val;
            srv6_pkg::CFG_SRC_IP_LOW:   exp_src_ip[63:0]   = val;
            srv6_pkg::CFG_DST_IP_HIGH:  exp_dst_ip[127:64] = val;
            srv6_pkg::CFG_DST_IP_LOW:   exp_dst_ip[63:0]   = val;
            srv6_pkg::CFG_NEXT_HOP_MAC: exp_next_hop_mac   = val[srv6_pkg::MAC_W-1:0];
            srv6_pkg::CFG_OWN_MAC:      exp_own_mac        = val[srv6_pkg::MAC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_addresses(input logic [srv6_pkg::IP_W-1:0] src,
                                     input logic [srv6_pkg::IP_W-1:0] dst,
                                     input logic [srv6_pkg::MAC_W-1:0] nh_mac,
                                     input logic [srv6_pkg::MAC_W-1:0] my_mac);
        write_reg(srv6_pkg::CFG_SRC_IP_HIGH, src[127:64]);
        write_reg(srv6_pkg::CFG_SRC_IP_LOW, src[63:0]);
        write_reg(srv6_pkg::CFG_DST_IP_HIGH, dst[127:64]);
        write_reg(srv6_pkg::CFG_DST_IP_LOW, dst[63:0]);
        write_reg(srv6_pkg::CFG_NEXT_HOP_MAC, {16'h0, nh_mac});
        write_reg(srv6_pkg::CFG_OWN_MAC, {16'h0, my_mac});
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one word; returns after the transaction is accepted.
    task automatic send_word(input logic [srv6_pkg::WORD_W-1:0] data,
                             input logic [srv6_pkg::VB_W-1:0] vb,
                             input logic first,
                             input logic last,
                             input logic [srv6_pkg::LEN_W-1:0] plen);
        int gap;
        gap = 0;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_word     <= data;
        in_ch.valid_bytes   <= vb;
        in_ch.first_word    <= first;
        in_ch.last_word     <= last;
        in_ch.payload_bytes <= plen;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (first || exp_frame_open)
            items_sent++;
        predict_encap(data, vb, first, last, plen);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [srv6_pkg::VB_W-1:0] VB_VAL(input bit one);
        return one ? srv6_pkg::VB_ONE : srv6_pkg::VB_TWO;
    endfunction

    // Well-formed frame of random content; close=0 leaves it open (truncated).
    task automatic send_frame(input int n_words, input bit close);
        logic [srv6_pkg::VB_W-1:0]  tail_vb;
        logic [srv6_pkg::VB_W-1:0]  vb;
        logic [srv6_pkg::LEN_W-1:0] plen;
        logic                       last;
        int unsigned                nbytes;
        tail_vb = VB_VAL(($urandom_range(1) == 0));
        nbytes  = 2 * n_words - ((tail_vb == srv6_pkg::VB_ONE) ? 1 : 0);
        plen    = ($urandom_range(9) == 0) ? srv6_pkg::LEN_W'($urandom)
                                           : srv6_pkg::LEN_W'(nbytes);
        for (int i = 0; i < n_words; i++)
        begin
            last = close && (i == n_words - 1);
            if (last)
                vb = tail_vb;
            else
                vb = ($urandom_range(7) == 0) ? srv6_pkg::VB_W'($urandom)
                                              : srv6_pkg::VB_TWO;
            send_word(srv6_pkg::WORD_W'($urandom), vb, i == 0, last,
                      (i == 0) ? plen : srv6_pkg::LEN_W'($urandom));
        end
    endtask

    // output side: random stall, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        enc_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_words.size() == 0)
                report_error($sformatf("unexpected word %h", out_ch.out_word));
            else
            begin
                want = pending_words.pop_front();
                if (out_ch.out_word !== want.word)
                    report_error($sformatf("word %0d: out_word %h, expected %h",
                                           words_checked, out_ch.out_word, want.word));
                if (out_ch.out_valid_bytes !== want.vb)
                    report_error($sformatf("word %0d: out_valid_bytes %0d, expected %0d",
                                           words_checked, out_ch.out_valid_bytes, want.vb));
                if (out_ch.run_end !== want.run_end)
                    report_error($sformatf("word %0d: run_end %b, expected %b",
                                           words_checked, out_ch.run_end, want.run_end));
                if (out_ch.packet_end !== want.packet_end)
                    report_error($sformatf("word %0d: packet_end %b, expected %b",
                                           words_checked, out_ch.packet_end,
                                           want.packet_end));
            end
            words_checked++;
        end
    end

    task automatic test_reset_defaults();
        // single-word frame, zero length, registers still at reset
        send_word(16'hFFFF, srv6_pkg::VB_TWO, 1'b1, 1'b1, 12'd0);
        wait_idle();
    endtask

    task automatic test_directed();
        // words with no frame open are dropped
        send_word(16'hFFFF, srv6_pkg::VB_TWO, 1'b0, 1'b0, 12'hFFF);
        send_word(16'h1234, srv6_pkg::VB_ONE, 1'b0, 1'b1, 12'h000);
        // over-long length saturates; every valid_bytes code
        send_word(16'h0000, srv6_pkg::VB_TWO, 1'b1, 1'b0, 12'hFFF);
        send_word(16'hA5A5, 2'd0, 1'b0, 1'b0, 12'h000);
        send_word(16'h5A5A, 2'd3, 1'b0, 1'b0, 12'hFFF);
        send_word(16'hFFFF, srv6_pkg::VB_ONE, 1'b0, 1'b1, 12'h000);
        // length exactly at the bound, odd first word
        send_word(16'hFFFF, srv6_pkg::VB_ONE, 1'b1, 1'b0, 12'(srv6_pkg::MAX_PAYLOAD));
        send_word(16'h8001, srv6_pkg::VB_TWO, 1'b0, 1'b1, 12'h555);
        // first word inside an open frame restarts it
        send_word(16'h0F0F, srv6_pkg::VB_TWO, 1'b1, 1'b0,
                  12'(srv6_pkg::MAX_PAYLOAD + 1));
        send_word(16'hF0F0, srv6_pkg::VB_TWO, 1'b0, 1'b0, 12'hAAA);
        send_word(16'h7E7E, srv6_pkg::VB_TWO, 1'b1, 1'b0, 12'd1);
        send_word(16'h00FF, srv6_pkg::VB_ONE, 1'b0, 1'b1, 12'd1);
        // single-word frame with one byte
        send_word(16'hC3C3, srv6_pkg::VB_ONE, 1'b1, 1'b1, 12'd64);
        // stray word after the frame closed
        send_word(16'hBEEF, srv6_pkg::VB_TWO, 1'b0, 1'b1, 12'd7);
        send_word(16'h4242, 2'd3, 1'b1, 1'b1, 12'd2);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n_items);
        int target;
        int pick;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                send_frame(($urandom_range(9) == 0) ? $urandom_range(20, 48)
                                                    : $urandom_range(1, 10), 1'b1);
            else if (pick < 90)
                send_word(srv6_pkg::WORD_W'($urandom), srv6_pkg::VB_W'($urandom), 1'b0,
                          1'($urandom), srv6_pkg::LEN_W'($urandom));
            else
                send_frame($urandom_range(1, 6), 1'b0);
        end
        send_frame($urandom_range(1, 4), 1'b1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        // output held off long enough that the queue fills and input stalls
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left   = 400;
        send_frame(24, 1'b1);
        send_frame(3, 1'b1);
        wait_idle();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.data_word     = '0;
        in_ch.valid_bytes   = srv6_pkg::VB_TWO;
        in_ch.first_word    = 1'b0;
        in_ch.last_word     = 1'b0;
        in_ch.payload_bytes = '0;
        out_ch.ready        = 1'b0;
        exp_src_ip          = '0;
        exp_dst_ip          = '0;
        exp_next_hop_mac    = '0;
        exp_own_mac         = '0;
        exp_frame_open      = 1'b0;
        errors              = 0;
        words_checked       = 0;
        items_sent          = 0;
        tx_idle_pct         = 0;
        rx_idle_pct         = 0;
        hold_left           = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        program_addresses({$urandom, $urandom, $urandom, $urandom},
                          {$urandom, $urandom, $urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
        test_directed();

        program_addresses('1, '1, '1, '1);
        tx_idle_pct = 7;
        rx_idle_pct = 86;
        test_random_traffic(70);

        program_addresses({$urandom, $urandom, $urandom, $urandom},
                          {$urandom, $urandom, $urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
        tx_idle_pct = 86;
        rx_idle_pct = 7;
        test_random_traffic(70);

        program_addresses('0, '0, '0, '0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(70);

        program_addresses({$urandom, $urandom, $urandom, $urandom},
                          {$urandom, $urandom, $urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
        test_backpressure();

        if (pending_words.size() != 0)
            report_error($sformatf("%0d expected words never arrived",
                                   pending_words.size()));
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/srv6_pkg.sv
hdl/srv6_if.sv
hdl/srv6_front.sv
hdl/srv6_fifo.sv
hdl/srv6_back.sv
hdl/srv6_l2_encapsulator.sv
hdl/srv6_checker.sv
test/tb_top.sv
